[design/complex_arithmetic_unit_core_defines.svh]
// ----------------------------------------------------------------------------
// Complex arithmetic unit assertion macros
// Shared helpers for the concurrent checks on the core's stream ports.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_CORE_DEFINES_SVH

// check a property on every clock edge outside reset
`define CAU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property on every clock edge, reset included
`define CAU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/cau_pkg.sv]
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Request codes, queue and pipeline types, divider and saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);
  localparam int unsigned DIV_STEPS = 33;
  localparam int unsigned DV_LAST   = DIV_STEPS + 1;
  localparam int unsigned FRAC_BITS = 16;

  localparam logic [2:0] REQ_ADD = 3'd0;
  localparam logic [2:0] REQ_SUB = 3'd1;
  localparam logic [2:0] REQ_MUL = 3'd2;
  localparam logic [2:0] REQ_DIV = 3'd3;
  localparam logic [2:0] REQ_EQ  = 3'd4;
  localparam logic [2:0] REQ_MAG = 3'd5;

  typedef enum logic [2:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_MAG} op_t;

  typedef struct packed {
    op_t                op;
    logic               nop;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } q_entry_t;

  typedef struct packed {
    op_t                op;
    logic               nop;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
    logic signed [63:0] p0;
    logic signed [63:0] p1;
    logic signed [63:0] p2;
    logic signed [63:0] p3;
    logic signed [63:0] p4;
    logic signed [63:0] p5;
  } s1_t;

  typedef struct packed {
    op_t                op;
    logic               nop;
    logic               cmp;
    logic signed [64:0] num_re;
    logic signed [64:0] num_im;
    logic [63:0]        den;
  } s2_t;

  typedef struct packed {
    op_t         op;
    logic        nop;
    logic        cmp;
    logic        dz;
    logic        neg_re;
    logic        neg_im;
    logic        pre_re;
    logic        pre_im;
    logic [63:0] mag_re;
    logic [63:0] mag_im;
    logic [63:0] den;
    logic [63:0] rem_re;
    logic [63:0] rem_im;
    logic [32:0] q_re;
    logic [32:0] q_im;
  } dv_t;

  typedef struct packed {
    logic        q;
    logic [63:0] rem;
  } dstep_t;

  typedef struct packed {
    logic [31:0] val;
    logic        ovf;
  } sat_t;

  function automatic logic signed [64:0] sext65(input logic signed [31:0] x);
    return {{33{x[31]}}, x};
  endfunction

  function automatic logic signed [64:0] sext65w(input logic signed [63:0] x);
    return {x[63], x};
  endfunction

  function automatic dstep_t div_bit(input logic [63:0] rem, input logic [63:0] den,
                                     input logic b);
    logic [64:0] t;
    dstep_t      r;
    t = {rem, b};
    if (t >= {1'b0, den}) begin
      r.q   = 1'b1;
      r.rem = 64'(t - {1'b0, den});
    end else begin
      r.q   = 1'b0;
      r.rem = t[63:0];
    end
    return r;
  endfunction

  function automatic sat_t sat32(input logic neg, input logic [63:0] mag);
    sat_t r;
    if (neg) begin
      if (mag > 64'h0000_0000_8000_0000) begin
        r.val = 32'h8000_0000;
        r.ovf = 1'b1;
      end else begin
        r.val = 32'h0000_0000 - mag[31:0];
        r.ovf = 1'b0;
      end
    end else begin
      if (mag > 64'h0000_0000_7FFF_FFFF) begin
        r.val = 32'h7FFF_FFFF;
        r.ovf = 1'b1;
      end else begin
        r.val = mag[31:0];
        r.ovf = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[design/complex_arithmetic_unit_core.sv]
// ----------------------------------------------------------------------------
// Complex arithmetic unit core
// Add, subtract, multiply, divide and compare two Q16.16 complex operands.
// ----------------------------------------------------------------------------
// One request per cycle is accepted while the queue has room, and one result
// per cycle is delivered while the output is not stalled; each result passes
// through the three multiply/sum/sign stages, the 34 stages of the pipelined
// restoring divider that every operation passes through, and the output register.
// A four-entry queue after the input lets the input keep taking requests
// while the output is stalled.
`default_nettype none

module complex_arithmetic_unit_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [127:0] s_tdata,   // a_re, a_im, b_re, b_im
  input  wire logic [2:0]   s_tuser,   // req_type
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [71:0]       m_tdata    // res_re, res_im, cmp_true, overflow, div_zero, pad
);

  logic              q_valid;
  logic              pop;
  cau_pkg::q_entry_t q_head;

  cau_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .pop      (pop)
  );

  cau_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

[design/cau_front.sv]
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Accepts requests, decodes the operation code and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [127:0]     s_tdata,
  input  wire logic [2:0]       s_tuser,
  output logic                  q_valid,
  output cau_pkg::q_entry_t     q_head,
  input  wire logic             pop
);

  cau_pkg::q_entry_t mem [cau_pkg::QDEPTH];
  cau_pkg::q_entry_t in_entry;
  logic [cau_pkg::QPTR_W-1:0] wr_ptr;
  logic [cau_pkg::QPTR_W-1:0] rd_ptr;
  logic [cau_pkg::QPTR_W:0]   count;
  logic                       push;
  logic                       take;

  assign s_tready = (count != (cau_pkg::QPTR_W + 1)'(cau_pkg::QDEPTH));
  assign q_valid  = (count != '0);
  assign push     = s_tvalid && s_tready;
  assign take     = q_valid && pop;
  assign q_head   = mem[rd_ptr];

  always_comb begin
    in_entry.a_re = s_tdata[31:0];
    in_entry.a_im = s_tdata[63:32];
    in_entry.b_re = s_tdata[95:64];
    in_entry.b_im = s_tdata[127:96];
    in_entry.nop  = 1'b0;
    case (s_tuser)
      cau_pkg::REQ_ADD: in_entry.op = cau_pkg::OP_ADD;
      cau_pkg::REQ_SUB: in_entry.op = cau_pkg::OP_SUB;
      cau_pkg::REQ_MUL: in_entry.op = cau_pkg::OP_MUL;
      cau_pkg::REQ_DIV: in_entry.op = cau_pkg::OP_DIV;
      cau_pkg::REQ_EQ:  in_entry.op = cau_pkg::OP_EQ;
      cau_pkg::REQ_MAG: in_entry.op = cau_pkg::OP_MAG;
      default: begin
        in_entry.op  = cau_pkg::OP_ADD;
        in_entry.nop = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/cau_back.sv]
// ----------------------------------------------------------------------------
// Complex arithmetic unit back end
// Multiply, sum, pipelined restoring divide and saturation of queued requests.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire cau_pkg::q_entry_t q_head,
  output logic                   pop,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [71:0]            m_tdata
);

  logic               adv;
  logic               v1;
  logic               v2;
  logic [cau_pkg::DV_LAST:0] vd;
  cau_pkg::s1_t       s1;
  cau_pkg::s2_t       s2;
  cau_pkg::s2_t       s2_next;
  cau_pkg::dv_t       dv [cau_pkg::DV_LAST+1];
  cau_pkg::dv_t       dv0_next;
  cau_pkg::dv_t       dv1_next;
  logic signed [31:0] m0b;
  logic signed [31:0] m1b;
  logic signed [64:0] abs_re;
  logic signed [64:0] abs_im;
  cau_pkg::dv_t       fin;
  logic [63:0]        fmag_re;
  logic [63:0]        fmag_im;
  cau_pkg::sat_t      sr;
  cau_pkg::sat_t      si;
  logic [31:0]        o_re;
  logic [31:0]        o_im;
  logic               o_cmp;
  logic               o_ovf;
  logic               o_dz;

  assign adv = !m_tvalid || m_tready;
  assign pop = adv;

  assign m0b = (q_head.op == cau_pkg::OP_MAG) ? q_head.a_re : q_head.b_re;
  assign m1b = (q_head.op == cau_pkg::OP_MAG) ? q_head.a_im : q_head.b_im;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1.op   <= q_head.op;
      s1.nop  <= q_head.nop;
      s1.a_re <= q_head.a_re;
      s1.a_im <= q_head.a_im;
      s1.b_re <= q_head.b_re;
      s1.b_im <= q_head.b_im;
      s1.p0   <= q_head.a_re * m0b;
      s1.p1   <= q_head.a_im * m1b;
      s1.p2   <= q_head.a_re * q_head.b_im;
      s1.p3   <= q_head.a_im * q_head.b_re;
      s1.p4   <= q_head.b_re * q_head.b_re;
      s1.p5   <= q_head.b_im * q_head.b_im;
    end
  end

  always_comb begin
    s2_next.op  = s1.op;
    s2_next.nop = s1.nop;
    s2_next.cmp = (s1.a_re == s1.b_re) && (s1.a_im == s1.b_im);
    s2_next.den = 64'($unsigned(s1.p4) + $unsigned(s1.p5));
    case (s1.op)
      cau_pkg::OP_ADD: begin
        s2_next.num_re = cau_pkg::sext65(s1.a_re) + cau_pkg::sext65(s1.b_re);
        s2_next.num_im = cau_pkg::sext65(s1.a_im) + cau_pkg::sext65(s1.b_im);
      end
      cau_pkg::OP_SUB: begin
        s2_next.num_re = cau_pkg::sext65(s1.a_re) - cau_pkg::sext65(s1.b_re);
        s2_next.num_im = cau_pkg::sext65(s1.a_im) - cau_pkg::sext65(s1.b_im);
      end
      cau_pkg::OP_MUL: begin
        s2_next.num_re = cau_pkg::sext65w(s1.p0) - cau_pkg::sext65w(s1.p1);
        s2_next.num_im = cau_pkg::sext65w(s1.p2) + cau_pkg::sext65w(s1.p3);
      end
      cau_pkg::OP_DIV: begin
        s2_next.num_re = cau_pkg::sext65w(s1.p0) + cau_pkg::sext65w(s1.p1);
        s2_next.num_im = cau_pkg::sext65w(s1.p3) - cau_pkg::sext65w(s1.p2);
      end
      default: begin
        s2_next.num_re = cau_pkg::sext65w(s1.p0) + cau_pkg::sext65w(s1.p1);
        s2_next.num_im = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2 <= s2_next;
    end
  end

  assign abs_re = s2.num_re[64] ? -s2.num_re : s2.num_re;
  assign abs_im = s2.num_im[64] ? -s2.num_im : s2.num_im;

  always_comb begin
    dv0_next        = '0;
    dv0_next.op     = s2.op;
    dv0_next.nop    = s2.nop;
    dv0_next.den    = s2.den;
    dv0_next.neg_re = s2.num_re[64];
    dv0_next.neg_im = s2.num_im[64];
    dv0_next.dz     = (s2.op == cau_pkg::OP_DIV) && (s2.den == '0);
    case (s2.op)
      cau_pkg::OP_EQ:  dv0_next.cmp = s2.cmp;
      cau_pkg::OP_MAG: dv0_next.cmp = (s2.num_re[63:0] > s2.den);
      default:         dv0_next.cmp = 1'b0;
    endcase
    if (s2.op == cau_pkg::OP_MUL) begin
      dv0_next.mag_re = {16'h0000, abs_re[63:16]};
      dv0_next.mag_im = {16'h0000, abs_im[63:16]};
    end else begin
      dv0_next.mag_re = abs_re[63:0];
      dv0_next.mag_im = abs_im[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0] <= dv0_next;
    end
  end

  always_comb begin
    dv1_next        = dv[0];
    dv1_next.rem_re = dv[0].mag_re >> (cau_pkg::DIV_STEPS - cau_pkg::FRAC_BITS);
    dv1_next.rem_im = dv[0].mag_im >> (cau_pkg::DIV_STEPS - cau_pkg::FRAC_BITS);
    dv1_next.pre_re = (dv1_next.rem_re >= dv[0].den);
    dv1_next.pre_im = (dv1_next.rem_im >= dv[0].den);
    dv1_next.q_re   = '0;
    dv1_next.q_im   = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv[1] <= dv1_next;
    end
  end

  for (genvar k = 1; k <= cau_pkg::DIV_STEPS; k++) begin : g_div
    localparam int BI = cau_pkg::DIV_STEPS - k;
    logic           bit_re;
    logic           bit_im;
    cau_pkg::dstep_t st_re;
    cau_pkg::dstep_t st_im;
    cau_pkg::dv_t    dv_next;

    if (BI >= cau_pkg::FRAC_BITS) begin : g_num
      assign bit_re = dv[k].mag_re[BI - cau_pkg::FRAC_BITS];
      assign bit_im = dv[k].mag_im[BI - cau_pkg::FRAC_BITS];
    end else begin : g_zero
      assign bit_re = 1'b0;
      assign bit_im = 1'b0;
    end

    assign st_re = cau_pkg::div_bit(dv[k].rem_re, dv[k].den, bit_re);
    assign st_im = cau_pkg::div_bit(dv[k].rem_im, dv[k].den, bit_im);

    always_comb begin
      dv_next        = dv[k];
      dv_next.rem_re = st_re.rem;
      dv_next.rem_im = st_im.rem;
      dv_next.q_re   = {dv[k].q_re[31:0], st_re.q};
      dv_next.q_im   = {dv[k].q_im[31:0], st_im.q};
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv[k+1] <= dv_next;
      end
    end
  end

  assign fin = dv[cau_pkg::DV_LAST];

  always_comb begin
    if (fin.op == cau_pkg::OP_DIV) begin
      fmag_re = fin.pre_re ? '1 : {31'h0, fin.q_re};
      fmag_im = fin.pre_im ? '1 : {31'h0, fin.q_im};
    end else begin
      fmag_re = fin.mag_re;
      fmag_im = fin.mag_im;
    end
  end

  assign sr = cau_pkg::sat32(fin.neg_re, fmag_re);
  assign si = cau_pkg::sat32(fin.neg_im, fmag_im);

  always_comb begin
    o_re  = '0;
    o_im  = '0;
    o_cmp = 1'b0;
    o_ovf = 1'b0;
    o_dz  = 1'b0;
    case (fin.op)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_MUL: begin
        o_re  = sr.val;
        o_im  = si.val;
        o_ovf = sr.ovf || si.ovf;
      end
      cau_pkg::OP_DIV: begin
        if (fin.dz) begin
          o_dz = 1'b1;
        end else begin
          o_re  = sr.val;
          o_im  = si.val;
          o_ovf = sr.ovf || si.ovf;
        end
      end
      cau_pkg::OP_EQ, cau_pkg::OP_MAG: begin
        o_cmp = fin.cmp;
      end
      default: begin
        o_cmp = 1'b0;
      end
    endcase
    if (fin.nop) begin
      o_re  = '0;
      o_im  = '0;
      o_cmp = 1'b0;
      o_ovf = 1'b0;
      o_dz  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {5'b00000, o_dz, o_ovf, o_cmp, o_im, o_re};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      vd       <= '0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      v1       <= q_valid;
      v2       <= v1;
      vd       <= {vd[cau_pkg::DV_LAST-1:0], v2};
      m_tvalid <= vd[cau_pkg::DV_LAST];
    end
  end

endmodule

`default_nettype wire

[design/cau_checker.sv]
// ----------------------------------------------------------------------------
// Complex arithmetic unit checker
// Port-level checks on input/output hold, flag consistency and idle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "complex_arithmetic_unit_core_defines.svh"

module cau_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tvalid,
  input wire logic         s_tready,
  input wire logic [127:0] s_tdata,
  input wire logic [2:0]   s_tuser,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [71:0]  m_tdata
);

  `CAU_ASSERT(a_in_hold, s_tvalid && !s_tready |=> s_tvalid && $stable({s_tuser, s_tdata}), "input not held")
  `CAU_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output not held")
  `CAU_ASSERT(a_dz_clean, m_tvalid && m_tdata[66] |-> m_tdata[65:0] == '0, "div_zero with data")
  `CAU_ASSERT(a_cmp_clean, m_tvalid && m_tdata[64] |-> m_tdata[63:0] == '0 && !m_tdata[65], "cmp with data")
  `CAU_ASSERT_ALWAYS(a_rst_idle, $past(rst) |-> !m_tvalid, "output valid after reset")

endmodule

bind complex_arithmetic_unit_core cau_checker u_cau_checker (.*);

`default_nettype wire
